// ===== rtl/core/particle_pool_allocator_top_defines.svh =====
// Assertion macros shared by the particle pool allocator RTL.
`ifndef PARTICLE_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define PARTICLE_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppa_pkg.sv =====
// Types and constants shared by the particle pool allocator modules.
package ppa_pkg;

  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  // Operation codes carried in the op field of an input word.
  typedef enum logic [1:0] {
    OP_SPAWN     = 2'd0,
    OP_KILL      = 2'd1,
    OP_RESET_ALL = 2'd2
  } ppa_op_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot_index;
  } ppa_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    logic               evicted;
    logic               error;
    logic [COUNT_W-1:0] active_count;
  } ppa_out_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SP_LINK,
    ST_EV_CUT,
    ST_EV_LINK,
    ST_KL_CHK,
    ST_KL_FREE,
    ST_RA_READ,
    ST_RA_FREE,
    ST_HOLD
  } ppa_state_e;

  // Datapath steps issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_SP_POP,
    CMD_EV_READ,
    CMD_KL_READ,
    CMD_KL_BAD,
    CMD_ACC_NOP,
    CMD_SP_LINK,
    CMD_EV_CUT,
    CMD_EV_LINK,
    CMD_KL_CHK,
    CMD_KL_FREE,
    CMD_RA_READ,
    CMD_RA_FREE
  } ppa_cmd_e;

  typedef struct packed {
    ppa_cmd_e step;
    logic     load_out;
  } ppa_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       free_empty;
    logic       tail_nil;
    logic       head_nil;
    logic       idx_ok;
    logic       prev_nil;
    logic       slot_active;
    logic       init_last;
    logic       out_free;
  } ppa_status_t;

endpackage

// ===== rtl/core/ppa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry when enabled, read one entry every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ppa_ctrl.sv =====
// Controller state machine that sequences the pool allocator datapath.
`include "particle_pool_allocator_top_defines.svh"

module ppa_ctrl
  import ppa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ppa_status_t status_i,
  output ppa_cmd_t    cmd_o
);

  ppa_state_e state_q, state_d;
  logic       finish;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick the next state and the datapath step
  always_comb begin
    state_d    = state_q;
    cmd_o      = '{step: CMD_NONE, load_out: 1'b0};
    in_ready_o = 1'b0;
    finish     = 1'b0;

    case (state_q)
      ST_INIT: begin
        cmd_o.step = CMD_INIT;
        if (status_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (status_i.op)
            OP_SPAWN: begin
              if (!status_i.free_empty) begin
                cmd_o.step = CMD_SP_POP;
                state_d    = ST_SP_LINK;
              end else if (!status_i.tail_nil) begin
                cmd_o.step = CMD_EV_READ;
                state_d    = ST_EV_CUT;
              end else begin
                cmd_o.step = CMD_ACC_NOP;
                finish     = 1'b1;
              end
            end
            OP_KILL: begin
              if (status_i.idx_ok) begin
                cmd_o.step = CMD_KL_READ;
                state_d    = ST_KL_CHK;
              end else begin
                cmd_o.step = CMD_KL_BAD;
                finish     = 1'b1;
              end
            end
            OP_RESET_ALL: begin
              cmd_o.step = CMD_ACC_NOP;
              state_d    = ST_RA_READ;
            end
            default: begin
              cmd_o.step = CMD_ACC_NOP;
              finish     = 1'b1;
            end
          endcase
        end
      end
      ST_SP_LINK: begin
        cmd_o.step = CMD_SP_LINK;
        finish     = 1'b1;
      end
      ST_EV_CUT: begin
        cmd_o.step = CMD_EV_CUT;
        if (status_i.prev_nil) begin
          finish = 1'b1;
        end else begin
          state_d = ST_EV_LINK;
        end
      end
      ST_EV_LINK: begin
        cmd_o.step = CMD_EV_LINK;
        finish     = 1'b1;
      end
      ST_KL_CHK: begin
        cmd_o.step = CMD_KL_CHK;
        if (!status_i.slot_active) begin
          finish = 1'b1;
        end else begin
          state_d = ST_KL_FREE;
        end
      end
      ST_KL_FREE: begin
        cmd_o.step = CMD_KL_FREE;
        finish     = 1'b1;
      end
      ST_RA_READ: begin
        cmd_o.step = CMD_RA_READ;
        if (status_i.head_nil) begin
          finish = 1'b1;
        end else begin
          state_d = ST_RA_FREE;
        end
      end
      ST_RA_FREE: begin
        cmd_o.step = CMD_RA_FREE;
        state_d    = ST_RA_READ;
      end
      ST_HOLD: begin
        finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Hand the result word to the output register, or wait for it to drain
    if (finish) begin
      if (status_i.out_free) begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_IDLE;
      end else begin
        state_d = ST_HOLD;
      end
    end
  end

  `PPA_ASSERT_IMPL(a_load_only_when_free, clk_i, rst_ni, cmd_o.load_out, status_i.out_free, "result loaded into a busy output register")

endmodule

// ===== rtl/core/ppa_dpath.sv =====
// Datapath: link memories, list pointers, counters and the output register.
`include "particle_pool_allocator_top_defines.svh"

module ppa_dpath
  import ppa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ppa_in_t     in_data_i,
  input  ppa_cmd_t    cmd_i,
  output ppa_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output ppa_out_t    out_data_o
);

  localparam int unsigned IW = $clog2(POOL_SLOTS);
  localparam int unsigned LW = $clog2(POOL_SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(POOL_SLOTS - 1);
  localparam logic [LW:0] META_FREE = {1'b0, NIL};

  // List pointers and counters
  logic [LW-1:0] free_top_q, free_top_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] tail_q, tail_d;
  logic [LW-1:0] total_q, total_d;
  logic [IW-1:0] init_q, init_d;
  logic          out_valid_q, out_valid_d;

  // Working slot and result fields
  logic [IW-1:0]     slot_q, slot_d;
  logic [SLOT_W-1:0] granted_q, granted_d;
  logic              evicted_q, evicted_d;
  logic              error_q, error_d;
  ppa_out_t          out_data_q, out_data_d;

  // Link memory ports: next links, and {active, prev link}
  logic          nx_we;
  logic [IW-1:0] nx_waddr, nx_raddr;
  logic [LW-1:0] nx_wdata, nx_rdata;
  logic          mt_we;
  logic [IW-1:0] mt_waddr, mt_raddr;
  logic [LW:0]   mt_wdata, mt_rdata;

  logic [LW-1:0] mt_prev;
  logic          mt_act;
  logic [IW-1:0] idx_slot;
  logic          idx_ok;

  ppa_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_SLOTS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (nx_raddr),
    .rdata_o (nx_rdata)
  );

  ppa_ram #(
    .WIDTH (LW + 1),
    .DEPTH (POOL_SLOTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (mt_we),
    .waddr_i (mt_waddr),
    .wdata_i (mt_wdata),
    .raddr_i (mt_raddr),
    .rdata_o (mt_rdata)
  );

  assign mt_prev  = mt_rdata[LW-1:0];
  assign mt_act   = mt_rdata[LW];
  assign idx_slot = IW'(in_data_i.slot_index);
  assign idx_ok   = 32'(in_data_i.slot_index) < 32'(POOL_SLOTS);

  // Execute the current step
  always_comb begin
    free_top_d = free_top_q;
    head_d     = head_q;
    tail_d     = tail_q;
    total_d    = total_q;
    init_d     = init_q;
    slot_d     = slot_q;
    granted_d  = granted_q;
    evicted_d  = evicted_q;
    error_d    = error_q;
    nx_we      = 1'b0;
    nx_waddr   = '0;
    nx_wdata   = '0;
    nx_raddr   = '0;
    mt_we      = 1'b0;
    mt_waddr   = '0;
    mt_wdata   = '0;
    mt_raddr   = '0;

    // Clear the result fields when a new word is taken
    if (cmd_i.step inside {CMD_SP_POP, CMD_EV_READ, CMD_KL_READ, CMD_KL_BAD, CMD_ACC_NOP}) begin
      granted_d = '0;
      evicted_d = 1'b0;
      error_d   = 1'b0;
    end

    case (cmd_i.step)
      CMD_INIT: begin
        // Build the free chain: slot i points at slot i-1
        nx_we    = 1'b1;
        nx_waddr = init_q;
        nx_wdata = (init_q == '0) ? NIL : LW'(init_q - IW'(1));
        mt_we    = 1'b1;
        mt_waddr = init_q;
        mt_wdata = META_FREE;
        init_d   = init_q + IW'(1);
      end
      CMD_SP_POP: begin
        // Pop the free top: fetch its next link, mark it active
        slot_d    = free_top_q[IW-1:0];
        nx_raddr  = free_top_q[IW-1:0];
        mt_we     = 1'b1;
        mt_waddr  = free_top_q[IW-1:0];
        mt_wdata  = {1'b1, NIL};
        granted_d = SLOT_W'(free_top_q[IW-1:0]);
      end
      CMD_EV_READ: begin
        // Fetch the tail's prev link for eviction
        slot_d    = tail_q[IW-1:0];
        mt_raddr  = tail_q[IW-1:0];
        granted_d = SLOT_W'(tail_q[IW-1:0]);
        evicted_d = 1'b1;
      end
      CMD_KL_READ: begin
        slot_d   = idx_slot;
        nx_raddr = idx_slot;
        mt_raddr = idx_slot;
      end
      CMD_KL_BAD: begin
        error_d = 1'b1;
      end
      CMD_SP_LINK: begin
        // Put the popped slot at the head of the active list
        free_top_d = nx_rdata;
        nx_we      = 1'b1;
        nx_waddr   = slot_q;
        nx_wdata   = head_q;
        if (head_q != NIL) begin
          mt_we    = 1'b1;
          mt_waddr = head_q[IW-1:0];
          mt_wdata = {1'b1, LW'(slot_q)};
        end else begin
          tail_d = LW'(slot_q);
        end
        head_d  = LW'(slot_q);
        total_d = total_q + LW'(1);
      end
      CMD_EV_CUT: begin
        // Cut the old tail off; a lone entry stays where it is
        if (mt_prev != NIL) begin
          nx_we    = 1'b1;
          nx_waddr = mt_prev[IW-1:0];
          nx_wdata = NIL;
          mt_we    = 1'b1;
          mt_waddr = slot_q;
          mt_wdata = {1'b1, NIL};
          tail_d   = mt_prev;
        end
      end
      CMD_EV_LINK: begin
        nx_we    = 1'b1;
        nx_waddr = slot_q;
        nx_wdata = head_q;
        mt_we    = 1'b1;
        mt_waddr = head_q[IW-1:0];
        mt_wdata = {1'b1, LW'(slot_q)};
        head_d   = LW'(slot_q);
      end
      CMD_KL_CHK: begin
        // Unlink the slot from its neighbors, or flag an inactive slot
        if (!mt_act) begin
          error_d = 1'b1;
        end else begin
          if (mt_prev != NIL) begin
            nx_we    = 1'b1;
            nx_waddr = mt_prev[IW-1:0];
            nx_wdata = nx_rdata;
          end else begin
            head_d = nx_rdata;
          end
          if (nx_rdata != NIL) begin
            mt_we    = 1'b1;
            mt_waddr = nx_rdata[IW-1:0];
            mt_wdata = {1'b1, mt_prev};
          end else begin
            tail_d = mt_prev;
          end
        end
      end
      CMD_KL_FREE: begin
        // Push the slot on the free stack
        nx_we      = 1'b1;
        nx_waddr   = slot_q;
        nx_wdata   = free_top_q;
        mt_we      = 1'b1;
        mt_waddr   = slot_q;
        mt_wdata   = META_FREE;
        free_top_d = LW'(slot_q);
        total_d    = (total_q != '0) ? total_q - LW'(1) : total_q;
      end
      CMD_RA_READ: begin
        // Fetch the head's next link, or close out the walk
        if (head_q != NIL) begin
          slot_d   = head_q[IW-1:0];
          nx_raddr = head_q[IW-1:0];
        end else begin
          tail_d = NIL;
        end
      end
      CMD_RA_FREE: begin
        // Free the old head and advance to its successor
        nx_we      = 1'b1;
        nx_waddr   = slot_q;
        nx_wdata   = free_top_q;
        mt_we      = 1'b1;
        mt_waddr   = slot_q;
        mt_wdata   = META_FREE;
        free_top_d = LW'(slot_q);
        head_d     = nx_rdata;
        total_d    = (total_q != '0) ? total_q - LW'(1) : total_q;
      end
      default: begin
      end
    endcase
  end

  // Load or drain the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.load_out) begin
      out_valid_d             = 1'b1;
      out_data_d.granted_slot = granted_d;
      out_data_d.evicted      = evicted_d;
      out_data_d.error        = error_d;
      out_data_d.active_count = COUNT_W'(total_d);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q  <= LW'(POOL_SLOTS - 1);
      head_q      <= NIL;
      tail_q      <= NIL;
      total_q     <= '0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_top_q  <= free_top_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    granted_q  <= granted_d;
    evicted_q  <= evicted_d;
    error_q    <= error_d;
    out_data_q <= out_data_d;
  end

  assign status_o.op          = in_data_i.op;
  assign status_o.free_empty  = (free_top_q == NIL);
  assign status_o.tail_nil    = (tail_q == NIL);
  assign status_o.head_nil    = (head_q == NIL);
  assign status_o.idx_ok      = idx_ok;
  assign status_o.prev_nil    = (mt_prev == NIL);
  assign status_o.slot_active = mt_act;
  assign status_o.init_last   = (init_q == LAST);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PPA_ASSERT_IMPL(a_empty_count_no_head, clk_i, rst_ni, total_q == '0, head_q == NIL, "active count is zero but the list has a head")
  `PPA_ASSERT_IMPL(a_free_empty_full_count, clk_i, rst_ni, free_top_q == NIL, total_q == NIL, "free stack empty but pool not fully active")
  `PPA_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, cmd_i.load_out, out_valid_q, "loaded result word not presented")

endmodule

// ===== rtl/core/particle_pool_allocator_top.sv =====
// Spawn takes a free slot, or evicts the tail when none is free; kill frees an active slot; reset-all frees all.
// One word in flight at a time; the next word is taken as soon as the sequencer is idle.
// Every step is bounded by one access per cycle to each of the two link RAMs.
// Reset: asynchronous, active low; then a sweep over all POOL_SLOTS slots builds the free chain
// in the link RAMs, with in_ready_o low until it ends.
module particle_pool_allocator_top
  import ppa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ppa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ppa_out_t out_data_o
);

  ppa_cmd_t    cmd;
  ppa_status_t status;

  ppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppa_dpath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
